// ===== hw/rtl/mv2_pkg.sv =====
// shared types, constants and the crc-16/mcrf4xx step for the mavlink v2 encoder
// depends on nothing; used by mv2_frame_state, the top level and the testbench
package mv2_pkg;

  localparam logic [7:0]  SOF_BYTE = 8'hfd;
  localparam logic [15:0] CRC_INIT = 16'hffff;

  localparam logic OP_START   = 1'b0;
  localparam logic OP_PAYLOAD = 1'b1;

  localparam int unsigned CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_SYS_ID  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_COMP_ID = 1'b1;

  typedef logic [3:0] beat_t;

  // beat codes: position of a result within the run of one item
  // a payload item uses BEAT_SOF for its data byte, then the two crc beats if it is the frame's last byte
  localparam beat_t BEAT_SOF    = 4'd0;
  localparam beat_t BEAT_LEN    = 4'd1;
  localparam beat_t BEAT_FLAGS0 = 4'd2;
  localparam beat_t BEAT_FLAGS1 = 4'd3;
  localparam beat_t BEAT_SEQ    = 4'd4;
  localparam beat_t BEAT_SYS    = 4'd5;
  localparam beat_t BEAT_COMP   = 4'd6;
  localparam beat_t BEAT_MID0   = 4'd7;
  localparam beat_t BEAT_MID1   = 4'd8;
  localparam beat_t BEAT_MID2   = 4'd9;
  localparam beat_t BEAT_CRC_LO = 4'd10;
  localparam beat_t BEAT_CRC_HI = 4'd11;

  typedef struct packed {
    logic        op;
    logic [23:0] msg_id;
    logic [7:0]  crc_seed;
    logic [7:0]  payload_length;
    logic [7:0]  payload_byte;
  } in_item_t;

  // one emitted byte, as seen by the frame state
  typedef struct packed {
    logic       fire;
    logic       op;
    beat_t      beat;
    logic [7:0] data;
    logic [7:0] length;
    logic [7:0] crc_seed;
  } emit_t;

  typedef struct packed {
    logic [7:0]  seq;
    logic [15:0] crc;
    logic [15:0] crc_fin;
    logic [7:0]  remaining;
    logic        open;
  } frame_t;

  function automatic logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
    logic [7:0] t;
    t = b ^ crc[7:0];
    t = t ^ {t[3:0], 4'b0000};
    return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
  endfunction

endpackage

// ===== hw/rtl/mv2_stream_if.sv =====
// valid/ready channels for input items and result items of the encoder
// depends on nothing
interface mv2_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [23:0] msg_id;
  logic [7:0]  crc_seed;
  logic [7:0]  payload_length;
  logic [7:0]  payload_byte;

  modport source (output valid, op, msg_id, crc_seed, payload_length, payload_byte,
                  input ready);
  modport sink (input valid, op, msg_id, crc_seed, payload_length, payload_byte,
                output ready);
endinterface

interface mv2_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_end;
  logic       run_last;

  modport source (output valid, out_byte, frame_end, run_last, input ready);
  modport sink (input valid, out_byte, frame_end, run_last, output ready);
endinterface

// ===== hw/rtl/mavlink_v2_frame_encoder.sv =====
// mavlink v2 frame encoder: one input item expands to a run of frame bytes
// an accepted item is registered first, and each of its result bytes is registered at the output
// throughput: one result byte per cycle while the receiver takes them; a start gives 10 bytes
// (12 if length is 0), a payload byte 1 byte (3 with the crc), a byte outside a frame no result
// the next item is taken in the cycle the previous run emits its last byte
// reset (synchronous): no frame open, sequence 0, crc 0xffff, ids 0, channels empty
module mavlink_v2_frame_encoder (
  input  logic                            clk,
  input  logic                            rst,
  mv2_in_if.sink                          item_in,
  mv2_out_if.source                       result_out,
  input  logic                            cfg_we,
  input  logic [mv2_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]                      cfg_data
);

  logic [7:0] sys_id;
  logic [7:0] comp_id;

  logic              run_valid;
  mv2_pkg::in_item_t run;
  mv2_pkg::beat_t    beat;
  mv2_pkg::beat_t    beat_next;

  logic out_valid;
  logic [7:0] out_byte;
  logic out_frame_end;
  logic out_run_last;

  mv2_pkg::emit_t  ev;
  mv2_pkg::frame_t fs;

  logic       drop;
  logic       emit;
  logic       last;
  logic       done;
  logic       accept;
  logic [7:0] sel_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      sys_id  <= 8'h00;
      comp_id <= 8'h00;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mv2_pkg::REG_SYS_ID:  sys_id  <= cfg_data;
        mv2_pkg::REG_COMP_ID: comp_id <= cfg_data;
        default: ;
      endcase
    end
  end

  // payload byte with no frame open leaves without a result
  assign drop = run_valid && run.op == mv2_pkg::OP_PAYLOAD && !fs.open;
  assign emit = run_valid && !drop && (!out_valid || result_out.ready);

  always_comb begin
    if (run.op == mv2_pkg::OP_START) begin
      last = (beat == mv2_pkg::BEAT_MID2 && run.payload_length != 8'h00)
             || beat == mv2_pkg::BEAT_CRC_HI;
    end else begin
      last = (beat == mv2_pkg::BEAT_SOF && fs.remaining != 8'd1)
             || beat == mv2_pkg::BEAT_CRC_HI;
    end
    if (run.op == mv2_pkg::OP_PAYLOAD && beat == mv2_pkg::BEAT_SOF) begin
      beat_next = mv2_pkg::BEAT_CRC_LO;
    end else begin
      beat_next = beat + 4'd1;
    end
  end

  assign done   = drop || (emit && last);
  assign accept = item_in.valid && item_in.ready;
  assign item_in.ready = !run_valid || done;

  always_comb begin
    unique case (beat)
      mv2_pkg::BEAT_SOF:
        sel_byte = (run.op == mv2_pkg::OP_START) ? mv2_pkg::SOF_BYTE : run.payload_byte;
      mv2_pkg::BEAT_LEN:    sel_byte = run.payload_length;
      mv2_pkg::BEAT_FLAGS0: sel_byte = 8'h00;
      mv2_pkg::BEAT_FLAGS1: sel_byte = 8'h00;
      mv2_pkg::BEAT_SEQ:    sel_byte = fs.seq;
      mv2_pkg::BEAT_SYS:    sel_byte = sys_id;
      mv2_pkg::BEAT_COMP:   sel_byte = comp_id;
      mv2_pkg::BEAT_MID0:   sel_byte = run.msg_id[7:0];
      mv2_pkg::BEAT_MID1:   sel_byte = run.msg_id[15:8];
      mv2_pkg::BEAT_MID2:   sel_byte = run.msg_id[23:16];
      mv2_pkg::BEAT_CRC_LO: sel_byte = fs.crc_fin[7:0];
      mv2_pkg::BEAT_CRC_HI: sel_byte = fs.crc[15:8];
      default:              sel_byte = 8'h00;
    endcase
  end

  assign ev.fire     = emit;
  assign ev.op       = run.op;
  assign ev.beat     = beat;
  assign ev.data     = sel_byte;
  assign ev.length   = run.payload_length;
  assign ev.crc_seed = run.crc_seed;

  mv2_frame_state u_frame_state (
    .clk (clk),
    .rst (rst),
    .ev  (ev),
    .st  (fs)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      run_valid <= 1'b0;
      beat      <= mv2_pkg::BEAT_SOF;
    end else if (accept) begin
      run_valid <= 1'b1;
      beat      <= mv2_pkg::BEAT_SOF;
    end else if (done) begin
      run_valid <= 1'b0;
      beat      <= mv2_pkg::BEAT_SOF;
    end else if (emit) begin
      beat <= beat_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      run.op             <= item_in.op;
      run.msg_id         <= item_in.msg_id;
      run.crc_seed       <= item_in.crc_seed;
      run.payload_length <= item_in.payload_length;
      run.payload_byte   <= item_in.payload_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte      <= sel_byte;
      out_frame_end <= (beat == mv2_pkg::BEAT_CRC_HI);
      out_run_last  <= last;
    end
  end

  assign result_out.valid     = out_valid;
  assign result_out.out_byte  = out_byte;
  assign result_out.frame_end = out_frame_end;
  assign result_out.run_last  = out_run_last;

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_frame_end) |-> out_run_last)
    else $error("frame end without run end");

  a_beat_holds: assert property (@(posedge clk) disable iff (rst)
    (run_valid && !drop && out_valid && !result_out.ready) |=> $stable(beat))
    else $error("beat moved while output stalled");

  a_beat_range: assert property (@(posedge clk) disable iff (rst)
    run_valid |-> beat <= mv2_pkg::BEAT_CRC_HI)
    else $error("beat past crc high byte");

  a_payload_beats: assert property (@(posedge clk) disable iff (rst)
    (run_valid && run.op == mv2_pkg::OP_PAYLOAD) |->
      (beat == mv2_pkg::BEAT_SOF || beat == mv2_pkg::BEAT_CRC_LO
       || beat == mv2_pkg::BEAT_CRC_HI))
    else $error("payload item on a header beat");

endmodule

// ===== hw/rtl/mv2_frame_state.sv =====
// frame state of the encoder: sequence number, running crc, payload count
// depends on mv2_pkg; updated once per emitted byte
module mv2_frame_state (
  input  logic           clk,
  input  logic           rst,
  input  mv2_pkg::emit_t ev,
  output mv2_pkg::frame_t st
);

  logic [7:0]  seq;
  logic [15:0] crc;
  logic [7:0]  remaining;
  logic [7:0]  extra;
  logic        open;

  assign st.seq       = seq;
  assign st.crc       = crc;
  assign st.crc_fin   = mv2_pkg::crc_step(crc, extra);
  assign st.remaining = remaining;
  assign st.open      = open;

  always_ff @(posedge clk) begin
    if (rst) begin
      seq       <= 8'h00;
      crc       <= mv2_pkg::CRC_INIT;
      remaining <= 8'h00;
      extra     <= 8'h00;
      open      <= 1'b0;
    end else if (ev.fire) begin
      if (ev.beat == mv2_pkg::BEAT_CRC_LO) begin
        crc <= st.crc_fin;
      end else if (ev.beat == mv2_pkg::BEAT_CRC_HI) begin
        open      <= 1'b0;
        remaining <= 8'h00;
      end else if (ev.op == mv2_pkg::OP_PAYLOAD) begin
        crc       <= mv2_pkg::crc_step(crc, ev.data);
        remaining <= remaining - 8'd1;
      end else if (ev.beat == mv2_pkg::BEAT_SOF) begin
        // a start abandons any open frame
        crc   <= mv2_pkg::CRC_INIT;
        extra <= ev.crc_seed;
      end else begin
        crc <= mv2_pkg::crc_step(crc, ev.data);
        if (ev.beat == mv2_pkg::BEAT_SEQ) begin
          seq <= seq + 8'd1;
        end
        if (ev.beat == mv2_pkg::BEAT_MID2) begin
          open      <= (ev.length != 8'h00);
          remaining <= ev.length;
        end
      end
    end
  end

  a_byte_in_frame: assert property (@(posedge clk) disable iff (rst)
    (ev.fire && ev.op == mv2_pkg::OP_PAYLOAD && ev.beat == mv2_pkg::BEAT_SOF)
    |-> (open && remaining != 8'h00))
    else $error("payload byte with no open frame or no bytes expected");

  a_end_closes: assert property (@(posedge clk) disable iff (rst)
    (ev.fire && ev.beat == mv2_pkg::BEAT_CRC_HI) |=> !open)
    else $error("frame still open after crc high byte");

  a_seq_step: assert property (@(posedge clk) disable iff (rst)
    (ev.fire && ev.op == mv2_pkg::OP_START && ev.beat == mv2_pkg::BEAT_SEQ)
    |=> seq == $past(seq) + 8'd1)
    else $error("sequence number did not advance on header");

endmodule

// ===== test/testbench.sv =====
// self-checking testbench for mavlink_v2_frame_encoder: drives start and payload items,
// predicts every frame byte with its own header, sequence and x.25 crc model
// depends on mv2_pkg, the mv2_in_if / mv2_out_if interfaces and the encoder rtl
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic [7:0] data;
    logic       frame_end;
    logic       run_last;
  } frame_byte_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [mv2_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [7:0] cfg_data;

  mv2_in_if  in_ch();
  mv2_out_if out_ch();

  mavlink_v2_frame_encoder uut (
    .clk        (clk),
    .rst        (rst),
    .item_in    (in_ch),
    .result_out (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // encoder model state
  logic [7:0]  sys_id_reg;
  logic [7:0]  comp_id_reg;
  logic [7:0]  frame_seq;
  logic [15:0] frame_crc;
  logic [7:0]  bytes_left;
  logic [7:0]  frame_extra;
  logic        frame_is_open;

  frame_byte_t pending_frame_bytes[$];

  int unsigned items_sent;
  int unsigned strays_dropped;
  int unsigned frames_closed;
  int unsigned results_seen;
  int unsigned mismatches;
  int unsigned cycle_count;
  int unsigned hold_request;
  bit          seq_wrapped;
  bit          sender_idles;
  bit          sink_idles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes outstanding", cycle_count,
               pending_frame_bytes.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // bit-serial x.25 accumulate, reflected polynomial
  function automatic logic [15:0] x25_accumulate(logic [15:0] acc, logic [7:0] b);
    logic [15:0] c;
    int k;
    c = acc ^ {8'h00, b};
    for (k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 16'h8408) : (c >> 1);
    return c;
  endfunction

  function automatic void add_frame_byte(logic [7:0] d, logic fe, logic rl);
    frame_byte_t fb;
    fb.data = d;
    fb.frame_end = fe;
    fb.run_last = rl;
    pending_frame_bytes = {pending_frame_bytes, fb};
  endfunction

  function automatic void close_frame();
    frame_crc = x25_accumulate(frame_crc, frame_extra);
    add_frame_byte(frame_crc[7:0], 1'b0, 1'b0);
    add_frame_byte(frame_crc[15:8], 1'b1, 1'b1);
    frame_is_open = 1'b0;
    bytes_left = 8'd0;
    frames_closed++;
  endfunction

  // works out the frame bytes that one accepted item produces
  function automatic void encode_frame_bytes(mv2_pkg::in_item_t it);
    logic [7:0] hdr [0:9];
    int k;
    if (it.op == mv2_pkg::OP_START) begin
      hdr[0] = mv2_pkg::SOF_BYTE;
      hdr[1] = it.payload_length;
      hdr[2] = 8'h00;
      hdr[3] = 8'h00;
      hdr[4] = frame_seq;
      hdr[5] = sys_id_reg;
      hdr[6] = comp_id_reg;
      hdr[7] = it.msg_id[7:0];
      hdr[8] = it.msg_id[15:8];
      hdr[9] = it.msg_id[23:16];
      if (frame_seq == 8'hff) seq_wrapped = 1'b1;
      frame_seq = frame_seq + 8'd1;
      frame_extra = it.crc_seed;
      frame_crc = mv2_pkg::CRC_INIT;
      // the start of frame marker stays out of the crc
      for (k = 0; k < 10; k++) begin
        if (k != 0) frame_crc = x25_accumulate(frame_crc, hdr[k]);
        add_frame_byte(hdr[k], 1'b0, (k == 9) && (it.payload_length != 8'd0));
      end
      if (it.payload_length == 8'd0) begin
        close_frame();
      end else begin
        frame_is_open = 1'b1;
        bytes_left = it.payload_length;
      end
      items_sent++;
    end else if (frame_is_open) begin
      frame_crc = x25_accumulate(frame_crc, it.payload_byte);
      bytes_left = bytes_left - 8'd1;
      add_frame_byte(it.payload_byte, 1'b0, bytes_left != 8'd0);
      if (bytes_left == 8'd0) close_frame();
      items_sent++;
    end else begin
      strays_dropped++;
    end
  endfunction

  // each item: optional gap, then hold valid until the encoder takes it
  task automatic send_item(mv2_pkg::in_item_t it);
    int unsigned gap;
    @(negedge clk);
    if (sender_idles && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 13);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.op             <= it.op;
    in_ch.msg_id         <= it.msg_id;
    in_ch.crc_seed       <= it.crc_seed;
    in_ch.payload_length <= it.payload_length;
    in_ch.payload_byte   <= it.payload_byte;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    encode_frame_bytes(it);
  endtask

  // drop valid and wait until every predicted byte has come out
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_frame_bytes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [mv2_pkg::CFG_INDEX_W-1:0] idx, logic [7:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == mv2_pkg::REG_SYS_ID) sys_id_reg = val;
    else comp_id_reg = val;
  endtask

  function automatic mv2_pkg::in_item_t random_item(logic op);
    mv2_pkg::in_item_t it;
    it.op             = op;
    it.msg_id         = 24'($urandom_range(0, 24'hffffff));
    it.crc_seed       = 8'($urandom_range(0, 255));
    it.payload_length = 8'($urandom_range(0, 255));
    it.payload_byte   = 8'($urandom_range(0, 255));
    return it;
  endfunction

  function automatic mv2_pkg::in_item_t make_item(logic op, logic [23:0] id,
                                                  logic [7:0] extra, logic [7:0] len,
                                                  logic [7:0] b);
    mv2_pkg::in_item_t it;
    it.op             = op;
    it.msg_id         = id;
    it.crc_seed       = extra;
    it.payload_length = len;
    it.payload_byte   = b;
    return it;
  endfunction

  task automatic send_frame(int unsigned len, int unsigned n_bytes);
    mv2_pkg::in_item_t it;
    int unsigned k;
    it = random_item(mv2_pkg::OP_START);
    it.payload_length = 8'(len);
    send_item(it);
    for (k = 0; k < n_bytes; k++) send_item(random_item(mv2_pkg::OP_PAYLOAD));
  endtask

  // mostly well-formed frames with random content, some strays and cut-off frames
  task automatic random_frames(int unsigned n_items);
    int unsigned goal;
    int unsigned pick;
    int unsigned len;
    int unsigned n_bytes;
    goal = items_sent + n_items;
    while (items_sent < goal) begin
      pick = $urandom_range(0, 19);
      if (pick < 2) begin
        send_item(random_item(mv2_pkg::OP_PAYLOAD));
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 3) len = 0;
        else if (pick < 8) len = $urandom_range(1, 6);
        else if (pick < 9) len = $urandom_range(7, 24);
        else len = $urandom_range(25, 255);
        n_bytes = len;
        // long frames are always cut short by the next start
        if (len != 0 && (len > 24 || $urandom_range(0, 7) == 0))
          n_bytes = $urandom_range(0, (len < 6) ? len - 1 : 5);
        send_frame(len, n_bytes);
      end
    end
  endtask

  task automatic test_directed_frames();
    write_reg(mv2_pkg::REG_SYS_ID, 8'hff);
    write_reg(mv2_pkg::REG_COMP_ID, 8'h00);
    // empty payloads at both ends of the id and extra ranges
    send_item(make_item(mv2_pkg::OP_START, 24'h000000, 8'h00, 8'd0, 8'h00));
    send_item(make_item(mv2_pkg::OP_START, 24'hffffff, 8'hff, 8'd0, 8'hff));
    // byte with no frame open
    send_item(make_item(mv2_pkg::OP_PAYLOAD, 24'hffffff, 8'hff, 8'hff, 8'h5a));
    send_item(make_item(mv2_pkg::OP_START, 24'h000102, 8'h32, 8'd2, 8'h00));
    send_item(make_item(mv2_pkg::OP_PAYLOAD, 24'h000000, 8'h00, 8'h00, 8'h00));
    send_item(make_item(mv2_pkg::OP_PAYLOAD, 24'h000000, 8'h00, 8'h00, 8'hff));
    // byte after the frame has closed
    send_item(make_item(mv2_pkg::OP_PAYLOAD, 24'h000000, 8'h00, 8'h00, 8'hff));
    // longest frame, abandoned by a new start
    send_item(make_item(mv2_pkg::OP_START, 24'h800000, 8'h80, 8'd255, 8'h00));
    send_item(make_item(mv2_pkg::OP_PAYLOAD, 24'hffffff, 8'hff, 8'hff, 8'h01));
    send_item(make_item(mv2_pkg::OP_PAYLOAD, 24'h555555, 8'h55, 8'h55, 8'h80));
    send_item(make_item(mv2_pkg::OP_START, 24'h123456, 8'h5c, 8'd1, 8'h00));
    send_item(make_item(mv2_pkg::OP_PAYLOAD, 24'h000000, 8'h00, 8'h00, 8'ha5));
    // open frame abandoned by an empty one
    send_item(make_item(mv2_pkg::OP_START, 24'h00aa55, 8'h11, 8'd3, 8'h00));
    send_item(make_item(mv2_pkg::OP_PAYLOAD, 24'h000000, 8'h00, 8'h00, 8'h7f));
    send_item(make_item(mv2_pkg::OP_START, 24'h7fffff, 8'h7f, 8'd0, 8'h00));
    send_item(make_item(mv2_pkg::OP_PAYLOAD, 24'h000000, 8'h00, 8'h00, 8'h33));
    settle();
  endtask

  task automatic test_backpressure();
    sender_idles = 1'b0;
    // long receiver hold while the sender keeps offering frames
    hold_request = 300;
    send_frame(12, 12);
    send_frame(0, 0);
    send_frame(12, 12);
    send_frame(9, 9);
    settle();
    send_frame(8, 8);
    send_frame(0, 0);
    settle();
    sender_idles = 1'b1;
  endtask

  task automatic test_register_settings();
    logic [7:0] sys_vals  [0:3];
    logic [7:0] comp_vals [0:3];
    int p;
    sys_vals[0] = 8'h00; comp_vals[0] = 8'h00;
    sys_vals[1] = 8'hff; comp_vals[1] = 8'hff;
    sys_vals[2] = 8'h80; comp_vals[2] = 8'h7f;
    sys_vals[3] = 8'($urandom_range(0, 255));
    comp_vals[3] = 8'($urandom_range(0, 255));
    for (p = 0; p < 4; p++) begin
      settle();
      write_reg(mv2_pkg::REG_SYS_ID, sys_vals[p]);
      write_reg(mv2_pkg::REG_COMP_ID, comp_vals[p]);
      random_frames(10);
    end
    settle();
  endtask

  // enough starts to carry the sequence number past 255
  task automatic test_sequence_wrap();
    write_reg(mv2_pkg::REG_SYS_ID, 8'h5a);
    write_reg(mv2_pkg::REG_COMP_ID, 8'ha5);
    while (!seq_wrapped) begin
      if ($urandom_range(0, 15) == 0) send_frame(1, 1);
      else send_frame(0, 0);
    end
    send_frame(2, 2);
    settle();
  endtask

  task automatic test_steady_stream();
    sender_idles = 1'b0;
    sink_idles = 1'b0;
    random_frames(25);
  endtask

  initial begin : receiver
    int unsigned stall_left;
    stall_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        stall_left = hold_request;
        hold_request = 0;
      end else if (stall_left == 0 && sink_idles && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 13);
      end
      if (stall_left != 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_checker
    frame_byte_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (pending_frame_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: byte %02h (end %0b last %0b) with nothing predicted",
                   out_ch.out_byte, out_ch.frame_end, out_ch.run_last);
      end else begin
        want = pending_frame_bytes.pop_front();
        if (want.data !== out_ch.out_byte || want.frame_end !== out_ch.frame_end ||
            want.run_last !== out_ch.run_last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at byte %0d: expected %02h/%0b/%0b, got %02h/%0b/%0b",
                     results_seen, want.data, want.frame_end, want.run_last,
                     out_ch.out_byte, out_ch.frame_end, out_ch.run_last);
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = mv2_pkg::REG_SYS_ID;
    cfg_data = 8'h00;
    in_ch.valid = 1'b0;
    in_ch.op = mv2_pkg::OP_START;
    in_ch.msg_id = 24'h000000;
    in_ch.crc_seed = 8'h00;
    in_ch.payload_length = 8'h00;
    in_ch.payload_byte = 8'h00;
    sys_id_reg = 8'h00;
    comp_id_reg = 8'h00;
    frame_seq = 8'h00;
    frame_crc = mv2_pkg::CRC_INIT;
    bytes_left = 8'h00;
    frame_extra = 8'h00;
    frame_is_open = 1'b0;
    items_sent = 0;
    strays_dropped = 0;
    frames_closed = 0;
    results_seen = 0;
    mismatches = 0;
    cycle_count = 0;
    hold_request = 0;
    seq_wrapped = 1'b0;
    sender_idles = 1'b1;
    sink_idles = 1'b1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_frames();
    test_backpressure();
    test_register_settings();
    test_sequence_wrap();
    test_steady_stream();
    settle();
    repeat (16) @(posedge clk);

    $display("run covered %0d frame items, %0d ignored stray bytes, %0d closed frames",
             items_sent, strays_dropped, frames_closed);
    $display("%0d output bytes compared, sequence wrap seen: %0b, %0d mismatches",
             results_seen, seq_wrapped, mismatches);
    if (mismatches == 0 && pending_frame_bytes.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
